// ===== hw/rtl/tevp_pkg.sv =====
// Shared types, character codes and arithmetic helpers for the terminal escape view parser.
package tevp_pkg;

  localparam int MAX_DIGITS_DEF = 5;
  localparam logic [7:0] DEFAULT_WIDTH = 8'd80;
  localparam logic [7:0] DEFAULT_HEIGHT = 8'd24;

  localparam logic [7:0] MAP_WIDTH_RST = 8'd128;
  localparam logic [7:0] MAP_HEIGHT_RST = 8'd64;
  localparam logic [3:0] BORDER_RST = 4'd1;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BORDER_WIDTH = 2'd2;

  localparam int STG_IDLE = 0;
  localparam int STG_ESC = 1;
  localparam int STG_CSI = 2;
  localparam int STG_EIGHT = 3;
  localparam int STG_NUM1 = 4;

  localparam logic [7:0] CH_ESC = 8'h1B;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_UP = 8'h41;
  localparam logic [7:0] CH_DOWN = 8'h42;
  localparam logic [7:0] CH_RIGHT = 8'h43;
  localparam logic [7:0] CH_LEFT = 8'h44;
  localparam logic [7:0] CH_EIGHT = 8'h38;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_T = 8'h74;
  localparam logic [7:0] CH_W = 8'h77;
  localparam logic [7:0] CH_A = 8'h61;
  localparam logic [7:0] CH_S = 8'h73;
  localparam logic [7:0] CH_D = 8'h64;
  localparam logic [7:0] CH_DIGIT_LO = 8'h30;
  localparam logic [7:0] CH_DIGIT_END = 8'h3A;

  localparam logic [8:0] NUM_SAT = 9'd256;
  localparam logic [7:0] BYTE_MAX = 8'd255;

  typedef struct packed {
    logic [8:0] first_num;
    logic [8:0] second_num;
    logic [7:0] view_x;
    logic [7:0] view_y;
    logic [7:0] cur_x;
    logic [7:0] cur_y;
    logic [7:0] win_w;
    logic [7:0] win_h;
  } view_state_t;

  typedef struct packed {
    logic [7:0] map_w;
    logic [7:0] map_h;
    logic [3:0] border;
  } view_cfg_t;

  typedef struct packed {
    logic [7:0] view_x;
    logic [7:0] view_y;
    logic [7:0] cursor_x;
    logic [7:0] cursor_y;
    logic [7:0] window_width;
    logic [7:0] window_height;
    logic       size_changed;
  } view_result_t;

  function automatic logic [8:0] acc_digit(logic [8:0] acc, logic [3:0] dig);
    logic [12:0] v;
    v = 13'({acc, 3'b000}) + 13'({acc, 1'b0}) + 13'(dig);
    return (v > 13'd255) ? NUM_SAT : v[8:0];
  endfunction

  function automatic logic can_grow(logic [7:0] pos, logic [7:0] map, logic [7:0] win,
                                    logic [3:0] border);
    logic [9:0] lhs;
    logic [9:0] rhs;
    lhs = 10'(pos) + 10'(win);
    rhs = 10'(map) + 10'({border, 1'b0});
    return (lhs < rhs) && (win < map) && (pos != BYTE_MAX);
  endfunction

  function automatic logic [7:0] sat_byte(logic [8:0] num);
    return num[8] ? BYTE_MAX : num[7:0];
  endfunction

endpackage

// ===== hw/rtl/tevp_step.sv =====
// Per-byte next-state logic: escape stage tracking, view scroll, cursor and size report.
module tevp_step #(
  parameter int MAX_DIGITS = tevp_pkg::MAX_DIGITS_DEF,
  localparam int STAGE_W = $clog2(6 + 2 * MAX_DIGITS)
) (
  input  logic [7:0]           rx_byte,
  input  logic [STAGE_W-1:0]   stage,
  input  tevp_pkg::view_state_t st,
  input  tevp_pkg::view_cfg_t  cfg,
  output logic [STAGE_W-1:0]   stage_nxt,
  output tevp_pkg::view_state_t st_nxt,
  output logic                 changed
);
  import tevp_pkg::*;

  localparam logic [STAGE_W-1:0] S_IDLE = STAGE_W'(STG_IDLE);
  localparam logic [STAGE_W-1:0] S_ESC = STAGE_W'(STG_ESC);
  localparam logic [STAGE_W-1:0] S_CSI = STAGE_W'(STG_CSI);
  localparam logic [STAGE_W-1:0] S_EIGHT = STAGE_W'(STG_EIGHT);
  localparam logic [STAGE_W-1:0] S_NUM1 = STAGE_W'(STG_NUM1);
  localparam logic [STAGE_W-1:0] S_NUM1_END = STAGE_W'(STG_NUM1 + MAX_DIGITS);
  localparam logic [STAGE_W-1:0] S_NUM2 = STAGE_W'(STG_NUM1 + MAX_DIGITS + 1);
  localparam logic [STAGE_W-1:0] S_NUM2_END = STAGE_W'(STG_NUM1 + 2 * MAX_DIGITS + 1);

  logic       is_digit;
  logic [7:0] h_new;
  logic [7:0] w_new;

  assign is_digit = (rx_byte >= CH_DIGIT_LO) && (rx_byte < CH_DIGIT_END);
  assign h_new = sat_byte(st.first_num);
  assign w_new = sat_byte(st.second_num);

  always_comb begin
    st_nxt = st;
    stage_nxt = S_IDLE;
    changed = 1'b0;
    priority if (rx_byte == CH_ESC && stage == S_IDLE) begin
      stage_nxt = S_ESC;
      st_nxt.first_num = '0;
      st_nxt.second_num = '0;
    end else if (rx_byte == CH_LBRACKET && stage == S_ESC) begin
      stage_nxt = S_CSI;
    end else if (rx_byte == CH_DOWN && stage == S_CSI) begin
      if (can_grow(st.view_y, cfg.map_h, st.win_h, cfg.border)) begin
        st_nxt.view_y = st.view_y + 8'd1;
      end
    end else if (rx_byte == CH_UP && stage == S_CSI) begin
      if (st.view_y != '0) begin
        st_nxt.view_y = st.view_y - 8'd1;
      end
    end else if (rx_byte == CH_LEFT && stage == S_CSI) begin
      if (st.view_x != '0) begin
        st_nxt.view_x = st.view_x - 8'd1;
      end
    end else if (rx_byte == CH_RIGHT && stage == S_CSI) begin
      if (can_grow(st.view_x, cfg.map_w, st.win_w, cfg.border)) begin
        st_nxt.view_x = st.view_x + 8'd1;
      end
    end else if (rx_byte == CH_W && stage == S_IDLE) begin
      stage_nxt = S_IDLE;
      if (st.cur_y != '0) begin
        st_nxt.cur_y = st.cur_y - 8'd1;
      end
    end else if (rx_byte == CH_S && stage == S_IDLE) begin
      stage_nxt = S_IDLE;
      if ((9'(st.cur_y) + 9'd1) < 9'(cfg.map_h)) begin
        st_nxt.cur_y = st.cur_y + 8'd1;
      end
    end else if (rx_byte == CH_D && stage == S_IDLE) begin
      stage_nxt = S_IDLE;
      if ((9'(st.cur_x) + 9'd1) < 9'(cfg.map_w)) begin
        st_nxt.cur_x = st.cur_x + 8'd1;
      end
    end else if (rx_byte == CH_A && stage == S_IDLE) begin
      stage_nxt = S_IDLE;
      if (st.cur_x != '0) begin
        st_nxt.cur_x = st.cur_x - 8'd1;
      end
    end else if (rx_byte == CH_EIGHT && stage == S_CSI) begin
      stage_nxt = S_EIGHT;
    end else if (rx_byte == CH_SEMI && stage == S_EIGHT) begin
      stage_nxt = S_NUM1;
    end else if (is_digit && stage >= S_NUM1 && stage < S_NUM1_END) begin
      st_nxt.first_num = acc_digit(st.first_num, rx_byte[3:0]);
      stage_nxt = stage + STAGE_W'(1);
    end else if (rx_byte == CH_SEMI && stage > S_NUM1 && stage <= S_NUM1_END) begin
      stage_nxt = S_NUM2;
    end else if (is_digit && stage >= S_NUM2 && stage < S_NUM2_END) begin
      st_nxt.second_num = acc_digit(st.second_num, rx_byte[3:0]);
      stage_nxt = stage + STAGE_W'(1);
    end else if (rx_byte == CH_T && stage > S_NUM2 && stage <= S_NUM2_END) begin
      if (w_new != st.win_w || h_new != st.win_h) begin
        st_nxt.view_x = '0;
        st_nxt.view_y = '0;
        st_nxt.win_w = w_new;
        st_nxt.win_h = h_new;
        changed = 1'b1;
      end
      st_nxt.first_num = '0;
      st_nxt.second_num = '0;
    end else begin
      stage_nxt = S_IDLE;
    end
  end

endmodule

// ===== hw/rtl/terminal_escape_view_parser_core.sv =====
// Top level of the terminal escape view parser: request registers, parser state, result register.
//
// Input channel: one received terminal byte per request (in_valid, in_stall, in_rx_byte).
// Result channel: one result per input byte (out_valid, out_stall, out_* fields) giving the
// view origin, cursor position and window size after that byte, plus a size-changed flag.
// Configuration: cfg_wr_en writes cfg_data into register cfg_index (0 map width,
// 1 map height, 2 border width); write only while no request is in flight.
// Path: a byte accepted into the request register is processed by single-level parser logic
// and lands in the result register when that register can advance (out_valid low or out_stall
// low); its result then shows on the output.
// Throughput: one byte per cycle while the result register is not held by out_stall.
// Reset (rst_n low, synchronous): parser idle, view and cursor at 0, window at its default
// size, configuration at its reset values, both channels empty.
// Stall: while out_stall holds a result, the request register keeps its byte and in_stall
// rises once it is full; nothing is dropped and parsing resumes when the stall clears.
module terminal_escape_view_parser_core #(
  parameter int MAX_DIGITS = tevp_pkg::MAX_DIGITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [tevp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tevp_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         in_rx_byte,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [7:0]                         out_view_x,
  output logic [7:0]                         out_view_y,
  output logic [7:0]                         out_cursor_x,
  output logic [7:0]                         out_cursor_y,
  output logic [7:0]                         out_window_width,
  output logic [7:0]                         out_window_height,
  output logic                               out_size_changed
);
  import tevp_pkg::*;

  localparam int STAGE_W = $clog2(6 + 2 * MAX_DIGITS);
  localparam logic [STAGE_W-1:0] STAGE_LAST = STAGE_W'(5 + 2 * MAX_DIGITS);

  view_cfg_t          cfg_r;
  logic               in_valid_r;
  logic [7:0]         in_byte_r;
  logic [STAGE_W-1:0] stage_r;
  logic [STAGE_W-1:0] stage_nxt;
  view_state_t        st_r;
  view_state_t        st_nxt;
  logic               changed;
  logic               out_valid_r;
  view_result_t       out_res_r;
  logic               advance;
  logic               step_en;

  assign advance = !out_valid_r || !out_stall;
  assign step_en = in_valid_r && advance;
  assign in_stall = in_valid_r && !advance;

  tevp_step #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_step (
    .rx_byte  (in_byte_r),
    .stage    (stage_r),
    .st       (st_r),
    .cfg      (cfg_r),
    .stage_nxt(stage_nxt),
    .st_nxt   (st_nxt),
    .changed  (changed)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.map_w <= MAP_WIDTH_RST;
      cfg_r.map_h <= MAP_HEIGHT_RST;
      cfg_r.border <= BORDER_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_MAP_WIDTH:    cfg_r.map_w <= cfg_data[7:0];
        CFG_MAP_HEIGHT:   cfg_r.map_h <= cfg_data[7:0];
        CFG_BORDER_WIDTH: cfg_r.border <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_byte_r <= in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= '0;
      st_r <= '{first_num: '0, second_num: '0, view_x: '0, view_y: '0,
                cur_x: '0, cur_y: '0, win_w: DEFAULT_WIDTH, win_h: DEFAULT_HEIGHT};
      out_valid_r <= 1'b0;
    end else begin
      if (step_en) begin
        stage_r <= stage_nxt;
        st_r <= st_nxt;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_res_r.view_x <= st_nxt.view_x;
      out_res_r.view_y <= st_nxt.view_y;
      out_res_r.cursor_x <= st_nxt.cur_x;
      out_res_r.cursor_y <= st_nxt.cur_y;
      out_res_r.window_width <= st_nxt.win_w;
      out_res_r.window_height <= st_nxt.win_h;
      out_res_r.size_changed <= changed;
    end
  end

  assign out_valid = out_valid_r;
  assign out_view_x = out_res_r.view_x;
  assign out_view_y = out_res_r.view_y;
  assign out_cursor_x = out_res_r.cursor_x;
  assign out_cursor_y = out_res_r.cursor_y;
  assign out_window_width = out_res_r.window_width;
  assign out_window_height = out_res_r.window_height;
  assign out_size_changed = out_res_r.size_changed;

  a_stage_range: assert property (@(posedge clk) disable iff (!rst_n)
    stage_r <= STAGE_LAST)
    else $error("parser stage out of range");

  a_size_change_resets_view: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && changed |=> out_valid_r && st_r.view_x == '0 && st_r.view_y == '0)
    else $error("size change did not reset view origin");

  a_cursor_x_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && st_nxt.cur_x > st_r.cur_x |-> st_nxt.cur_x < cfg_r.map_w)
    else $error("cursor column passed map width");

  a_cursor_y_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && st_nxt.cur_y > st_r.cur_y |-> st_nxt.cur_y < cfg_r.map_h)
    else $error("cursor row passed map height");

  a_state_held_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> $stable(stage_r) && $stable(st_r))
    else $error("parser state moved while request was blocked");

endmodule

// ===== sim/terminal_escape_view_parser_core_tb.sv =====
// Self-checking testbench for the terminal escape view parser core: byte traffic in, views checked.
module terminal_escape_view_parser_core_tb;
  import tevp_pkg::*;

  localparam int DIGITS = MAX_DIGITS_DEF;
  localparam int STG_NUM2 = STG_NUM1 + DIGITS + 1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_MAP_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_rx_byte = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_view_x;
  logic [7:0] out_view_y;
  logic [7:0] out_cursor_x;
  logic [7:0] out_cursor_y;
  logic [7:0] out_window_width;
  logic [7:0] out_window_height;
  logic out_size_changed;

  terminal_escape_view_parser_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_rx_byte(in_rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_view_x(out_view_x),
    .out_view_y(out_view_y),
    .out_cursor_x(out_cursor_x),
    .out_cursor_y(out_cursor_y),
    .out_window_width(out_window_width),
    .out_window_height(out_window_height),
    .out_size_changed(out_size_changed)
  );

  always #5 clk = ~clk;

  // parser state as predicted
  int seq_at;
  logic [8:0] rows_acc;
  logic [8:0] cols_acc;
  logic [7:0] org_x;
  logic [7:0] org_y;
  logic [7:0] cur_col;
  logic [7:0] cur_row;
  logic [7:0] win_w;
  logic [7:0] win_h;
  logic [7:0] map_w;
  logic [7:0] map_h;
  logic [3:0] border;

  view_result_t expected_views[$];
  int mismatch_count = 0;
  int sent_bytes = 0;
  bit steady = 1'b0;
  int stall_cycles;

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic logic [8:0] add_decimal(logic [8:0] acc, int dig);
    int v;
    v = int'(acc) * 10 + dig;
    return (v > 255) ? 9'd256 : 9'(v);
  endfunction

  function automatic bit view_can_advance(logic [7:0] pos, logic [7:0] span, logic [7:0] win);
    int limit;
    limit = int'(span) - int'(win) + 2 * int'(border);
    return (int'(pos) < limit) && (win < span) && (pos < BYTE_MAX);
  endfunction

  function automatic view_result_t parse_byte(logic [7:0] rx);
    int s;
    bit is_digit;
    logic changed;
    logic [7:0] h;
    logic [7:0] w;
    view_result_t res;
    s = seq_at;
    is_digit = (rx >= CH_DIGIT_LO) && (rx < CH_DIGIT_END);
    changed = 1'b0;
    if (rx == CH_ESC && s == STG_IDLE) begin
      seq_at = STG_ESC;
      rows_acc = '0;
      cols_acc = '0;
    end else if (rx == CH_LBRACKET && s == STG_ESC) begin
      seq_at = STG_CSI;
    end else if (rx == CH_DOWN && s == STG_CSI) begin
      if (view_can_advance(org_y, map_h, win_h)) begin
        org_y++;
      end
      seq_at = STG_IDLE;
    end else if (rx == CH_UP && s == STG_CSI) begin
      if (org_y != 0) begin
        org_y--;
      end
      seq_at = STG_IDLE;
    end else if (rx == CH_LEFT && s == STG_CSI) begin
      if (org_x != 0) begin
        org_x--;
      end
      seq_at = STG_IDLE;
    end else if (rx == CH_RIGHT && s == STG_CSI) begin
      if (view_can_advance(org_x, map_w, win_w)) begin
        org_x++;
      end
      seq_at = STG_IDLE;
    end else if (rx == CH_W && s == STG_IDLE) begin
      if (cur_row != 0) begin
        cur_row--;
      end
    end else if (rx == CH_S && s == STG_IDLE) begin
      if (int'(cur_row) < int'(map_h) - 1) begin
        cur_row++;
      end
    end else if (rx == CH_D && s == STG_IDLE) begin
      if (int'(cur_col) < int'(map_w) - 1) begin
        cur_col++;
      end
    end else if (rx == CH_A && s == STG_IDLE) begin
      if (cur_col != 0) begin
        cur_col--;
      end
    end else if (rx == CH_EIGHT && s == STG_CSI) begin
      seq_at = STG_EIGHT;
    end else if (rx == CH_SEMI && s == STG_EIGHT) begin
      seq_at = STG_NUM1;
    end else if (is_digit && s >= STG_NUM1 && s < STG_NUM1 + DIGITS) begin
      rows_acc = add_decimal(rows_acc, int'(rx - CH_DIGIT_LO));
      seq_at = s + 1;
    end else if (rx == CH_SEMI && s > STG_NUM1 && s <= STG_NUM1 + DIGITS) begin
      seq_at = STG_NUM2;
    end else if (is_digit && s >= STG_NUM2 && s < STG_NUM2 + DIGITS) begin
      cols_acc = add_decimal(cols_acc, int'(rx - CH_DIGIT_LO));
      seq_at = s + 1;
    end else if (rx == CH_T && s > STG_NUM2 && s <= STG_NUM2 + DIGITS) begin
      h = (rows_acc > 9'd255) ? BYTE_MAX : rows_acc[7:0];
      w = (cols_acc > 9'd255) ? BYTE_MAX : cols_acc[7:0];
      if (w != win_w || h != win_h) begin
        org_x = '0;
        org_y = '0;
        win_w = w;
        win_h = h;
        changed = 1'b1;
      end
      rows_acc = '0;
      cols_acc = '0;
      seq_at = STG_IDLE;
    end else begin
      seq_at = STG_IDLE;
    end
    res.view_x = org_x;
    res.view_y = org_y;
    res.cursor_x = cur_col;
    res.cursor_y = cur_row;
    res.window_width = win_w;
    res.window_height = win_h;
    res.size_changed = changed;
    return res;
  endfunction

  function automatic int pick_size(int current);
    case ($urandom_range(0, 5))
      0, 1: return $urandom_range(0, 20);
      2: return current;
      3: return $urandom_range(0, 255);
      4: return $urandom_range(256, 99999);
      default: return $urandom_range(0, 3);
    endcase
  endfunction

  function automatic int pick_digits(int v);
    int n;
    n = 1;
    while (v >= 10) begin
      v /= 10;
      n++;
    end
    if (n < DIGITS && $urandom_range(0, 2) == 0) begin
      n = $urandom_range(n, DIGITS);
    end
    return n;
  endfunction

  task automatic send_byte(input logic [7:0] rx);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= rx;
    do @(posedge clk); while (in_stall);
    expected_views.push_back(parse_byte(rx));
    sent_bytes++;
  endtask

  task automatic send_csi(input logic [7:0] final_byte);
    send_byte(CH_ESC);
    send_byte(CH_LBRACKET);
    send_byte(final_byte);
  endtask

  task automatic send_decimal(input int value, input int n);
    int scale;
    int i;
    scale = 1;
    for (i = 1; i < n; i++) scale *= 10;
    for (i = 0; i < n; i++) begin
      send_byte(8'(CH_DIGIT_LO + (value / scale) % 10));
      scale /= 10;
    end
  endtask

  task automatic send_report(input int rows, input int cols, input int rows_n, input int cols_n,
                             input logic [7:0] tail);
    send_byte(CH_ESC);
    send_byte(CH_LBRACKET);
    send_byte(CH_EIGHT);
    send_byte(CH_SEMI);
    send_decimal(rows, rows_n);
    send_byte(CH_SEMI);
    send_decimal(cols, cols_n);
    send_byte(tail);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_views.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_map(input logic [7:0] mw, input logic [7:0] mh, input logic [3:0] bw);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_MAP_WIDTH;
    cfg_data <= mw;
    @(posedge clk);
    cfg_index <= CFG_MAP_HEIGHT;
    cfg_data <= mh;
    @(posedge clk);
    cfg_index <= CFG_BORDER_WIDTH;
    cfg_data <= {4'($urandom), bw};
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    map_w = mw;
    map_h = mh;
    border = bw;
  endtask

  task automatic test_cursor_edges();
    send_byte(CH_W);
    send_byte(CH_A);
    send_byte(CH_D);
    send_byte(CH_S);
  endtask

  task automatic test_scroll_keys();
    send_csi(CH_UP);
    send_csi(CH_RIGHT);
  endtask

  task automatic test_size_report();
    send_report(99999, 0, DIGITS, 1, CH_T);
  endtask

  task automatic test_broken_input();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CH_ESC);
    send_byte(CH_ESC);
    send_csi(CH_S);
  endtask

  task automatic test_random_traffic();
    int phase;
    int stop;
    int pick;
    int rows;
    int cols;
    int depth;
    for (phase = 0; phase < 7; phase++) begin
      case (phase)
        0: write_map(MAP_WIDTH_RST, MAP_HEIGHT_RST, BORDER_RST);
        1: write_map(8'd1, 8'd1, 4'd0);
        2: write_map(8'd255, 8'd255, 4'd15);
        3: write_map(8'd1, 8'd255, 4'd15);
        4: write_map(8'd255, 8'd1, 4'd0);
        default: write_map(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                           4'($urandom_range(0, 15)));
      endcase
      steady = (phase % 3 == 2);
      stop = sent_bytes + 100;
      while (sent_bytes < stop) begin
        pick = $urandom_range(0, 99);
        rows = pick_size(int'(win_h));
        cols = pick_size(int'(win_w));
        if (pick < 35) begin
          case ($urandom_range(0, 3))
            0: send_csi(CH_UP);
            1: send_csi(CH_DOWN);
            2: send_csi(CH_LEFT);
            default: send_csi(CH_RIGHT);
          endcase
        end else if (pick < 60) begin
          case ($urandom_range(0, 3))
            0: send_byte(CH_W);
            1: send_byte(CH_A);
            2: send_byte(CH_S);
            default: send_byte(CH_D);
          endcase
        end else if (pick < 75) begin
          send_report(rows, cols, pick_digits(rows), pick_digits(cols), CH_T);
        end else if (pick < 88) begin
          case ($urandom_range(0, 5))
            0: begin
              send_byte(CH_ESC);
              depth = $urandom_range(0, 3);
              if (depth > 0) send_byte(CH_LBRACKET);
              if (depth > 1) send_byte(CH_EIGHT);
              if (depth > 2) send_byte(CH_SEMI);
              send_byte(8'($urandom_range(0, 255)));
            end
            1: send_report($urandom_range(0, 99999), cols, DIGITS + 1, pick_digits(cols), CH_T);
            2: send_report(rows, $urandom_range(0, 99999), pick_digits(rows), DIGITS + 1, CH_T);
            3: send_report(rows, cols, $urandom_range(0, 1) ? 0 : pick_digits(rows), 0, CH_T);
            4: send_report(rows, cols, pick_digits(rows), pick_digits(cols),
                           8'($urandom_range(0, 255)));
            default: begin
              send_byte(CH_ESC);
              send_byte(CH_LBRACKET);
              case ($urandom_range(0, 4))
                0: send_byte(CH_ESC);
                1: send_byte(CH_W);
                2: send_byte(CH_A);
                3: send_byte(CH_S);
                default: send_byte(CH_D);
              endcase
            end
          endcase
        end else begin
          send_byte(8'($urandom_range(0, 255)));
        end
      end
    end
    steady = 1'b0;
  endtask

  task automatic test_scroll_ceiling();
    write_map(8'd255, 8'd255, 4'd15);
    send_report(1, 1, 1, 1, CH_T);
    repeat (258) send_csi(CH_RIGHT);
    send_csi(CH_LEFT);
  endtask

  always begin
    stall_cycles = steady ? 0 : $urandom_range(0, 3);
    if (stall_cycles > 0) begin
      out_stall <= 1'b1;
      repeat (stall_cycles) @(posedge clk);
    end
    out_stall <= 1'b0;
    do @(posedge clk); while (!out_valid);
  end

  always @(posedge clk) begin : result_check
    view_result_t got;
    view_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got.view_x = out_view_x;
      got.view_y = out_view_y;
      got.cursor_x = out_cursor_x;
      got.cursor_y = out_cursor_y;
      got.window_width = out_window_width;
      got.window_height = out_window_height;
      got.size_changed = out_size_changed;
      if (expected_views.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected view result %p", got);
      end else begin
        want = expected_views.pop_front();
        if (got.view_x !== want.view_x || got.view_y !== want.view_y ||
            got.cursor_x !== want.cursor_x || got.cursor_y !== want.cursor_y ||
            got.window_width !== want.window_width ||
            got.window_height !== want.window_height ||
            got.size_changed !== want.size_changed) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("view mismatch: expected x=%0d y=%0d cx=%0d cy=%0d w=%0d h=%0d chg=%0d",
                     want.view_x, want.view_y, want.cursor_x, want.cursor_y,
                     want.window_width, want.window_height, want.size_changed);
            $display("               actual   x=%0d y=%0d cx=%0d cy=%0d w=%0d h=%0d chg=%0d",
                     got.view_x, got.view_y, got.cursor_x, got.cursor_y,
                     got.window_width, got.window_height, got.size_changed);
          end
        end
      end
    end
  end

  initial begin
    seq_at = STG_IDLE;
    rows_acc = '0;
    cols_acc = '0;
    org_x = '0;
    org_y = '0;
    cur_col = '0;
    cur_row = '0;
    win_w = DEFAULT_WIDTH;
    win_h = DEFAULT_HEIGHT;
    map_w = MAP_WIDTH_RST;
    map_h = MAP_HEIGHT_RST;
    border = BORDER_RST;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_cursor_edges();
    test_scroll_keys();
    test_size_report();
    test_broken_input();
    test_random_traffic();
    test_scroll_ceiling();
    settle();
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== terminal_escape_view_parser_core.f =====
hw/rtl/tevp_pkg.sv
hw/rtl/tevp_step.sv
hw/rtl/terminal_escape_view_parser_core.sv
sim/terminal_escape_view_parser_core_tb.sv
